// ===== rtl/insertion_sorter_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ISU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isu check failed");

// next-cycle implication
`define ISU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isu check failed");

`endif

// ===== rtl/isu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

  localparam int unsigned KeyW = 32;

  typedef logic signed [KeyW-1:0] key_t;

  // per-cell control from the top level
  typedef struct packed {
    logic insert;    // a key is inserted this cycle
    logic shift;     // drain: take the value of the right neighbor
    logic at_tail;   // this cell is the first free slot
    logic occupied;  // this cell holds a key
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/isu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// input request: one key of a set
interface isu_in_if;
  logic          valid;
  logic          ready;
  isu_pkg::key_t value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// output request: one sorted key
interface isu_out_if;
  logic          valid;
  logic          ready;
  isu_pkg::key_t sorted_value;
  logic          end_of_set;
  logic          overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/isu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isu_cell (
  input  wire logic                clk_i,
  input  wire isu_pkg::cell_ctrl_t ctrl_i,
  input  wire isu_pkg::key_t       key_i,
  input  wire logic                prev_gt_i,
  input  wire isu_pkg::key_t       prev_value_i,
  input  wire isu_pkg::key_t       next_value_i,
  output logic                     gt_o,
  output isu_pkg::key_t            value_o
);

  isu_pkg::key_t value_q, value_d;

  // strict greater keeps equal keys in arrival order
  assign gt_o    = ctrl_i.occupied && (value_q > key_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
    end else if (ctrl_i.insert && (gt_o || ctrl_i.at_tail)) begin
      value_d = prev_gt_i ? prev_value_i : key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/insertion_sorter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// insertion sorter: accepts one signed 32-bit key per cycle and keeps the keys of
// the current set in ascending order in a row of CAPACITY compare-and-shift cells.
// each input request is inserted in the cycle it is accepted: every cell compares
// its key with the broadcast key and either keeps its key, takes its left
// neighbor's key, or takes the new key. equal keys keep arrival order. when the
// request marked last is accepted, the block drains the row through cell 0, one
// sorted key per output request, with end_of_set on the final key and overflow
// on every key of a set that lost keys to a full row. the input is not ready until
// the final key of the set has been taken; outside draining the rate is one key per
// cycle. keys arriving while the row is full are dropped.

module insertion_sorter_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isu_in_if.sink     in_i,
  isu_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // control state
  logic [CntW-1:0] count_q, count_d;
  logic            drain_q, drain_d;
  logic            dropped_q, dropped_d;

  logic accept_in, insert, drop, pop, final_pop;

  // the cell chain
  logic                gt    [CAPACITY];
  isu_pkg::key_t       value [CAPACITY];
  isu_pkg::cell_ctrl_t ctrl  [CAPACITY];

  // handshakes: no new key while the set is being drained
  assign in_i.ready = !drain_q;
  assign accept_in  = in_i.valid && in_i.ready;
  assign insert     = accept_in && (count_q < CntW'(CAPACITY));
  assign drop       = accept_in && (count_q == CntW'(CAPACITY));
  assign pop        = drain_q && out_o.ready;
  assign final_pop  = pop && (count_q == CntW'(1));

  // cell 0 is the head of the sorted row
  assign out_o.valid        = drain_q;
  assign out_o.sorted_value = value[0];
  assign out_o.end_of_set   = (count_q == CntW'(1));
  assign out_o.overflow     = dropped_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          prev_gt;
    isu_pkg::key_t prev_value;
    isu_pkg::key_t next_value;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = value[i];
    end else begin : g_body
      assign prev_gt    = gt[i-1];
      assign prev_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = value[i];
    end else begin : g_mid
      assign next_value = value[i+1];
    end

    assign ctrl[i].insert   = insert;
    assign ctrl[i].shift    = pop;
    assign ctrl[i].at_tail  = (count_q == CntW'(i));
    assign ctrl[i].occupied = (CntW'(i) < count_q);

    isu_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .key_i        (in_i.value),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .gt_o         (gt[i]),
      .value_o      (value[i])
    );
  end

  // fill count, drain mode and overflow flag
  always_comb begin
    count_d   = count_q;
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (insert) begin
      count_d = count_q + CntW'(1);
    end else if (pop) begin
      count_d = count_q - CntW'(1);
    end
    if (drop) begin
      dropped_d = 1'b1;
    end
    if (accept_in && in_i.last) begin
      drain_d = 1'b1;
    end
    if (final_pop) begin
      drain_d   = 1'b0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      drain_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      drain_q   <= drain_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "insertion_sorter_unit_assert.svh"

module isu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_end_i,
  input wire logic out_overflow_i
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // input is held off while a set drains
  `ISU_ASSERT_NOW(a_no_input_while_drain, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // a last key starts the drain
  `ISU_ASSERT_NEXT(a_last_starts_drain, clk_i, rst_ni, in_acc && in_last_i, out_valid_i)
  // a key that is not last gives no result
  `ISU_ASSERT_NEXT(a_plain_key_silent, clk_i, rst_ni, in_acc && !in_last_i, !out_valid_i)
  // more results follow until end of set, with the same overflow mark
  `ISU_ASSERT_NEXT(a_drain_continues, clk_i, rst_ni, out_acc && !out_end_i,
                   out_valid_i && (out_overflow_i == $past(out_overflow_i)))
  // the final result frees the input
  `ISU_ASSERT_NEXT(a_end_frees_input, clk_i, rst_ni, out_acc && out_end_i,
                   !out_valid_i && in_ready_i)

endmodule

bind insertion_sorter_unit isu_checker u_isu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_end_i      (out_o.end_of_set),
  .out_overflow_i (out_o.overflow)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ROW_DEPTH   = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // how the keys of a random set are drawn
  typedef enum int {
    KEYS_WIDE,
    KEYS_CLUSTERED,
    KEYS_EXTREME
  } key_mix_e;

  typedef struct {
    isu_pkg::key_t value;
    logic          last;
  } key_req_t;

  typedef struct {
    isu_pkg::key_t value;
    logic          end_of_set;
    logic          overflow;
  } sorted_res_t;

  logic clk_i;
  logic rst_ni;

  isu_in_if  in_bus ();
  isu_out_if out_bus ();

  insertion_sorter_unit #(
    .CAPACITY(ROW_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  key_req_t    key_pending_q[$];
  sorted_res_t sorted_q[$];

  // shadow of the sorting row
  isu_pkg::key_t row_keys[ROW_DEPTH];
  int unsigned   row_count;
  logic          row_dropped;

  int          error_count;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned hold_req_cnt;
  int unsigned hold_ack_cnt;
  int unsigned hold_left;

  // insert one key and, on the last one, emit the set in order
  task automatic sort_into_row(key_req_t req);
    int unsigned pos;
    sorted_res_t res;
    if (row_count < ROW_DEPTH) begin
      pos = row_count;
      while (pos > 0 && row_keys[pos-1] > req.value) begin
        row_keys[pos] = row_keys[pos-1];
        pos--;
      end
      row_keys[pos] = req.value;
      row_count++;
    end else begin
      row_dropped = 1'b1;
    end
    if (req.last) begin
      for (int unsigned k = 0; k < row_count; k++) begin
        res.value      = row_keys[k];
        res.end_of_set = (k + 1 == row_count);
        res.overflow   = row_dropped;
        sorted_q.push_back(res);
      end
      row_count   = 0;
      row_dropped = 1'b0;
    end
  endtask

  function automatic isu_pkg::key_t pick_key(key_mix_e mix);
    case (mix)
      KEYS_CLUSTERED: pick_key = $signed(32'($urandom_range(8))) - 4;
      KEYS_EXTREME: begin
        case ($urandom_range(3))
          0:       pick_key = 32'sh8000_0000;
          1:       pick_key = 32'sh7fff_ffff;
          2:       pick_key = 32'sh0000_0000;
          default: pick_key = 32'shffff_ffff;
        endcase
      end
      default: pick_key = $urandom;
    endcase
  endfunction

  task automatic queue_key(isu_pkg::key_t value, logic last);
    key_req_t req;
    req.value = value;
    req.last  = last;
    key_pending_q.push_back(req);
  endtask

  // one set of len keys; returns the number of keys queued
  task automatic queue_key_set(int len, output int queued);
    key_mix_e mix;
    case ($urandom_range(5))
      0, 1:    mix = KEYS_CLUSTERED;
      2:       mix = KEYS_EXTREME;
      default: mix = KEYS_WIDE;
    endcase
    for (int i = 0; i < len; i++) queue_key(pick_key(mix), i == len - 1);
    queued = len;
  endtask

  task automatic wait_quiet();
    while (key_pending_q.size() != 0 || in_bus.valid || sorted_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(int send_pct, int recv_pct, int n_items);
    int total;
    int queued;
    int len;
    total          = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (total < n_items) begin
      // mostly sets that fit, now and then one that overflows the row
      if ($urandom_range(7) == 0) len = $urandom_range(ROW_DEPTH + 6, ROW_DEPTH + 1);
      else if ($urandom_range(5) == 0) len = ROW_DEPTH;
      else len = $urandom_range(ROW_DEPTH, 1);
      queue_key_set(len, queued);
      total += queued;
    end
    wait_quiet();
  endtask

  task automatic report_mismatch(sorted_res_t want, sorted_res_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch: expected key %0d eos %0b ovf %0b, got key %0d eos %0b ovf %0b",
               want.value, want.end_of_set, want.overflow,
               got.value, got.end_of_set, got.overflow);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver: valid stays up until the key is taken
  always @(posedge clk_i) begin : key_driver
    logic offering;
    if (rst_ni) begin
      offering = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        sort_into_row(key_pending_q[0]);
        key_pending_q.delete(0);
        offering = 1'b0;
      end
      if (!offering) begin
        if (key_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid <= 1'b1;
          in_bus.value <= key_pending_q[0].value;
          in_bus.last  <= key_pending_q[0].last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i) begin : sorted_monitor
    sorted_res_t got;
    sorted_res_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.value      = out_bus.sorted_value;
        got.end_of_set = out_bus.end_of_set;
        got.overflow   = out_bus.overflow;
        if (sorted_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: key %0d eos %0b ovf %0b",
                     got.value, got.end_of_set, got.overflow);
        end else begin
          want = sorted_q.pop_front();
          if (got.value !== want.value || got.end_of_set !== want.end_of_set ||
              got.overflow !== want.overflow)
            report_mismatch(want, got);
        end
      end
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long output hold-off, started on request
  always @(posedge clk_i) begin : hold_timer
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_left    <= HOLD_CYCLES;
      hold_ack_cnt <= hold_ack_cnt + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int queued;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.value     = '0;
    in_bus.last      = 1'b0;
    out_bus.ready    = 1'b0;
    row_count        = 0;
    row_dropped      = 1'b0;
    error_count      = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req_cnt     = 0;
    hold_ack_cnt     = 0;
    hold_left        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single key set at the top of the range
    queue_key(32'sh7fff_ffff, 1'b1);
    // extremes, with the most negative key twice and last
    queue_key(32'sh0000_0000, 1'b0);
    queue_key(32'shffff_ffff, 1'b0);
    queue_key(32'sh7fff_ffff, 1'b0);
    queue_key(32'sh8000_0000, 1'b0);
    queue_key(32'sh0000_0001, 1'b0);
    queue_key(32'sh8000_0000, 1'b1);
    // descending set that overruns the row; the last key falls off too
    for (int i = 0; i < ROW_DEPTH + 2; i++)
      queue_key(100 - i, i == ROW_DEPTH + 1);
    wait_quiet();

    random_phase(0, 0, 45);
    random_phase(88, 0, 45);
    random_phase(0, 88, 45);
    random_phase(23, 23, 45);

    // output held off while keys keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt   = hold_req_cnt + 1;
    queue_key_set(10, queued);
    queue_key_set(ROW_DEPTH + 4, queued);
    queue_key_set(6, queued);
    wait_quiet();

    // output hold-off above, then a last mixed stretch
    random_phase(23, 23, 20);

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && sorted_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/isu_pkg.sv
rtl/isu_if.sv
rtl/isu_cell.sv
rtl/insertion_sorter_unit.sv
rtl/isu_checker.sv
tb/tb_top.sv
